// ===== design/fpa_pkg.sv =====
// package: default widths, operation codes and status codes of the q24.8 alu
package fpa_pkg;

  // default word and fraction widths
  localparam int WORD_BITS     = 32;
  localparam int FRACTION_BITS = 8;

  // operation codes
  typedef enum logic [3:0] {
    CMD_ADD      = 4'd0,
    CMD_SUB      = 4'd1,
    CMD_MUL      = 4'd2,
    CMD_DIV      = 4'd3,
    CMD_GT       = 4'd4,
    CMD_LT       = 4'd5,
    CMD_GE       = 4'd6,
    CMD_LE       = 4'd7,
    CMD_EQ       = 4'd8,
    CMD_NE       = 4'd9,
    CMD_MIN      = 4'd10,
    CMD_MAX      = 4'd11,
    CMD_INC      = 4'd12,
    CMD_DEC      = 4'd13,
    CMD_FROM_INT = 4'd14,
    CMD_TO_INT   = 4'd15
  } cmd_e;

  // status codes
  localparam logic [1:0] STS_OK   = 2'd0;
  localparam logic [1:0] STS_OVF  = 2'd1;
  localparam logic [1:0] STS_DIVZ = 2'd2;

endpackage

// ===== design/fpa_if.sv =====
// interfaces: operand word channel and result word channel

// operand word channel
interface fpa_in_if #(
  parameter int WordBits = fpa_pkg::WORD_BITS
);
  logic                valid;
  logic                ready;
  logic [3:0]          cmd;
  logic [WordBits-1:0] first_operand;
  logic [WordBits-1:0] second_operand;

  modport source (output valid, cmd, first_operand, second_operand, input ready);
  modport sink   (input valid, cmd, first_operand, second_operand, output ready);
endinterface

// result word channel
interface fpa_out_if #(
  parameter int WordBits = fpa_pkg::WORD_BITS
);
  logic                valid;
  logic                ready;
  logic [WordBits-1:0] result_value;
  logic                compare_true;
  logic [1:0]          status;

  modport source (output valid, result_value, compare_true, status, input ready);
  modport sink   (input valid, result_value, compare_true, status, output ready);
endinterface

// ===== design/fixed_point_alu_q24_8_top.sv =====
// top level: pipelined signed fixed-point alu with saturation and rounding
// throughput: one word per cycle while the output stage is not stalled; the divider retires one quotient bit per stage
// the multiplier sits in stage 1 and its rounding in stage 2
// the whole pipeline advances when the output stage is empty or taken
// reset clears all valid bits asynchronously; payload registers are not reset
module fixed_point_alu_q24_8_top #(
  parameter int WordBits = fpa_pkg::WORD_BITS,
  parameter int FracBits = fpa_pkg::FRACTION_BITS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  fpa_in_if.sink   in_i,
  fpa_out_if.source out_o
);

  localparam int W    = WordBits;
  localparam int N    = WordBits + FracBits;
  localparam int LAST = N + 1;

  localparam logic [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};

  // per-stage registers
  logic                vld_q [0:LAST];
  logic                vld_d [0:LAST];
  fpa_pkg::cmd_e       cmd_q [0:LAST];
  fpa_pkg::cmd_e       cmd_d [0:LAST];
  logic                neg_q [0:LAST];
  logic                neg_d [0:LAST];
  logic                dz_q  [0:LAST];
  logic                dz_d  [0:LAST];
  logic [W-1:0]        res_q [0:LAST];
  logic [W-1:0]        res_d [0:LAST];
  logic                cmp_q [0:LAST];
  logic                cmp_d [0:LAST];
  logic [1:0]          sts_q [0:LAST];
  logic [1:0]          sts_d [0:LAST];
  logic [W:0]          rem_q [0:LAST];
  logic [W:0]          rem_d [0:LAST];
  logic [N-1:0]        quo_q [0:LAST];
  logic [N-1:0]        quo_d [0:LAST];
  logic [N-1:0]        num_q [0:LAST];
  logic [N-1:0]        num_d [0:LAST];
  logic [W-1:0]        dvs_q [0:LAST];
  logic [W-1:0]        dvs_d [0:LAST];

  // multiplier operand and product registers
  logic [W-1:0]        ma_q, ma_d;
  logic [2*W-1:0]      prod_q, prod_d;

  logic en;

  // pipeline advance
  assign en          = !vld_q[LAST] || out_o.ready;
  assign in_i.ready  = en;

  // stage 0 operand decode and the operations that stage 0 completes
  logic [W-1:0] a, b, opb, sum, ma, mb;
  logic         is_sub, risk, ovf, lt, eq;
  fpa_pkg::cmd_e cmd_in;

  // later stages: divider steps, multiply rounding, divide rounding
  logic [W:0]     remsh;
  logic [2*W:0]   mpr, mmag, mlim;
  logic [N:0]     qr, qlim;
  logic           rup;

  // product of magnitudes, registered alongside stage 1
  assign prod_d = ma_q * dvs_q[0];

  always_comb begin
    cmd_in = fpa_pkg::cmd_e'(in_i.cmd);
    a      = in_i.first_operand;
    b      = in_i.second_operand;
    is_sub = (cmd_in == fpa_pkg::CMD_SUB) || (cmd_in == fpa_pkg::CMD_DEC);
    opb    = ((cmd_in == fpa_pkg::CMD_INC) || (cmd_in == fpa_pkg::CMD_DEC))
             ? {{(W-1){1'b0}}, 1'b1} : b;
    sum    = is_sub ? (a - opb) : (a + opb);
    risk   = is_sub ? (a[W-1] != opb[W-1]) : (a[W-1] == opb[W-1]);
    ovf    = risk && (sum[W-1] != a[W-1]);
    lt     = $signed(a) < $signed(b);
    eq     = (a == b);
    ma     = a[W-1] ? (~a + 1'b1) : a;
    mb     = b[W-1] ? (~b + 1'b1) : b;

    vld_d[0] = in_i.valid;
    cmd_d[0] = cmd_in;
    neg_d[0] = a[W-1] ^ b[W-1];
    dz_d[0]  = (b == '0);
    rem_d[0] = '0;
    quo_d[0] = '0;
    num_d[0] = {ma, {FracBits{1'b0}}};
    dvs_d[0] = mb;
    ma_d     = ma;
    res_d[0] = '0;
    cmp_d[0] = 1'b0;
    sts_d[0] = fpa_pkg::STS_OK;

    unique case (cmd_in)
      fpa_pkg::CMD_ADD, fpa_pkg::CMD_SUB, fpa_pkg::CMD_INC, fpa_pkg::CMD_DEC: begin
        res_d[0] = ovf ? (a[W-1] ? MINW : MAXW) : sum;
        sts_d[0] = ovf ? fpa_pkg::STS_OVF : fpa_pkg::STS_OK;
      end
      fpa_pkg::CMD_MUL, fpa_pkg::CMD_DIV: begin
        res_d[0] = '0;
      end
      fpa_pkg::CMD_GT: cmp_d[0] = !lt && !eq;
      fpa_pkg::CMD_LT: cmp_d[0] = lt;
      fpa_pkg::CMD_GE: cmp_d[0] = !lt;
      fpa_pkg::CMD_LE: cmp_d[0] = lt || eq;
      fpa_pkg::CMD_EQ: cmp_d[0] = eq;
      fpa_pkg::CMD_NE: cmp_d[0] = !eq;
      fpa_pkg::CMD_MIN: res_d[0] = (lt || eq) ? a : b;
      fpa_pkg::CMD_MAX: res_d[0] = !lt ? a : b;
      fpa_pkg::CMD_FROM_INT: begin
        // fits when the top FracBits+1 bits are all equal
        if ((a[W-1 -: FracBits+1] == '0) || (a[W-1 -: FracBits+1] == '1)) begin
          res_d[0] = a << FracBits;
        end else begin
          res_d[0] = a[W-1] ? MINW : MAXW;
          sts_d[0] = fpa_pkg::STS_OVF;
        end
      end
      fpa_pkg::CMD_TO_INT: res_d[0] = W'($signed(a) >>> FracBits);
      default: res_d[0] = '0;
    endcase

    // later stages
    mpr   = '0;
    mmag  = '0;
    mlim  = '0;
    qr    = '0;
    qlim  = '0;
    rup   = 1'b0;
    remsh = '0;
    for (int k = 1; k <= LAST; k++) begin
      vld_d[k] = vld_q[k-1];
      cmd_d[k] = cmd_q[k-1];
      neg_d[k] = neg_q[k-1];
      dz_d[k]  = dz_q[k-1];
      res_d[k] = res_q[k-1];
      cmp_d[k] = cmp_q[k-1];
      sts_d[k] = sts_q[k-1];
      dvs_d[k] = dvs_q[k-1];
      rem_d[k] = rem_q[k-1];
      quo_d[k] = quo_q[k-1];
      num_d[k] = num_q[k-1];
      // one restoring quotient bit per stage
      if (k <= N) begin
        remsh    = {rem_q[k-1][W-1:0], num_q[k-1][N-1]};
        num_d[k] = {num_q[k-1][N-2:0], 1'b0};
        if (remsh >= {1'b0, dvs_q[k-1]}) begin
          rem_d[k] = remsh - {1'b0, dvs_q[k-1]};
          quo_d[k] = {quo_q[k-1][N-2:0], 1'b1};
        end else begin
          rem_d[k] = remsh;
          quo_d[k] = {quo_q[k-1][N-2:0], 1'b0};
        end
      end
    end

    // multiply: round half away from zero, then saturate
    if (cmd_q[1] == fpa_pkg::CMD_MUL) begin
      mpr  = {1'b0, prod_q} + ((2*W+1)'(1) << (FracBits-1));
      mmag = mpr >> FracBits;
      mlim = {{(W+1){1'b0}}, neg_q[1], {(W-1){~neg_q[1]}}};
      if (mmag > mlim) begin
        res_d[2] = neg_q[1] ? MINW : MAXW;
        sts_d[2] = fpa_pkg::STS_OVF;
      end else begin
        res_d[2] = neg_q[1] ? (~mmag[W-1:0] + 1'b1) : mmag[W-1:0];
      end
    end

    // divide: round on remainder, then saturate or flag zero divisor
    if (cmd_q[N] == fpa_pkg::CMD_DIV) begin
      rup  = {rem_q[N], 1'b0} >= {2'b00, dvs_q[N]};
      qr   = {1'b0, quo_q[N]} + {{N{1'b0}}, rup};
      qlim = {{(FracBits+1){1'b0}}, neg_q[N], {(W-1){~neg_q[N]}}};
      if (dz_q[N]) begin
        res_d[LAST] = '0;
        sts_d[LAST] = fpa_pkg::STS_DIVZ;
      end else if (qr > qlim) begin
        res_d[LAST] = neg_q[N] ? MINW : MAXW;
        sts_d[LAST] = fpa_pkg::STS_OVF;
      end else begin
        res_d[LAST] = neg_q[N] ? (~qr[W-1:0] + 1'b1) : qr[W-1:0];
      end
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= LAST; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k <= LAST; k++) vld_q[k] <= vld_d[k];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k <= LAST; k++) begin
        cmd_q[k] <= cmd_d[k];
        neg_q[k] <= neg_d[k];
        dz_q[k]  <= dz_d[k];
        res_q[k] <= res_d[k];
        cmp_q[k] <= cmp_d[k];
        sts_q[k] <= sts_d[k];
        rem_q[k] <= rem_d[k];
        quo_q[k] <= quo_d[k];
        num_q[k] <= num_d[k];
        dvs_q[k] <= dvs_d[k];
      end
      ma_q   <= ma_d;
      prod_q <= prod_d;
    end
  end

  // result word
  assign out_o.valid        = vld_q[LAST];
  assign out_o.result_value = res_q[LAST];
  assign out_o.compare_true = cmp_q[LAST];
  assign out_o.status       = sts_q[LAST];

endmodule

// ===== test/fpa_alu_checker.sv =====
// checker: predicts each q24.8 alu result word and compares it with the output channel
module fpa_alu_checker (
  input  logic      clk_i,
  input  logic      rst_ni,
  fpa_in_if.sink    op_mon,
  fpa_out_if.sink   res_mon,
  output int        fail_count,
  output int        pending_count,
  output int        result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] value;
    logic        cmp;
    logic [1:0]  sts;
  } alu_result_t;

  localparam logic signed [31:0] POS_LIMIT = 32'sh7fffffff;
  localparam logic signed [31:0] NEG_LIMIT = 32'sh80000000;

  alu_result_t awaited_results[$];

  // clamp a wide signed value into the word
  function automatic alu_result_t clamp_word(logic signed [127:0] v);
    alu_result_t r;
    r = '0;
    if (v > 128'(POS_LIMIT)) begin
      r.value = POS_LIMIT;
      r.sts = fpa_pkg::STS_OVF;
    end else if (v < 128'(NEG_LIMIT)) begin
      r.value = NEG_LIMIT;
      r.sts = fpa_pkg::STS_OVF;
    end else begin
      r.value = v[31:0];
    end
    return r;
  endfunction

  // exact arithmetic in 128 bits, rounding to nearest with ties away from zero
  function automatic alu_result_t compute_alu(fpa_pkg::cmd_e op, logic signed [31:0] a,
                                              logic signed [31:0] b);
    alu_result_t r;
    logic signed [127:0] wa, wb, wide;
    logic [127:0] ma, mb, mq, mr;
    logic neg;
    r = '0;
    wa = 128'(a);
    wb = 128'(b);
    ma = a[31] ? -wa : wa;
    mb = b[31] ? -wb : wb;
    neg = a[31] ^ b[31];
    case (op)
      fpa_pkg::CMD_ADD: r = clamp_word(wa + wb);
      fpa_pkg::CMD_SUB: r = clamp_word(wa - wb);
      fpa_pkg::CMD_MUL: begin
        mq = (ma * mb + 128'd128) >> fpa_pkg::FRACTION_BITS;
        wide = neg ? -$signed(mq) : $signed(mq);
        r = clamp_word(wide);
      end
      fpa_pkg::CMD_DIV: begin
        if (b == 0) begin
          r.sts = fpa_pkg::STS_DIVZ;
        end else begin
          mq = (ma << fpa_pkg::FRACTION_BITS) / mb;
          mr = (ma << fpa_pkg::FRACTION_BITS) % mb;
          if (2 * mr >= mb) mq = mq + 1;
          wide = neg ? -$signed(mq) : $signed(mq);
          r = clamp_word(wide);
        end
      end
      fpa_pkg::CMD_GT: r.cmp = a > b;
      fpa_pkg::CMD_LT: r.cmp = a < b;
      fpa_pkg::CMD_GE: r.cmp = a >= b;
      fpa_pkg::CMD_LE: r.cmp = a <= b;
      fpa_pkg::CMD_EQ: r.cmp = a == b;
      fpa_pkg::CMD_NE: r.cmp = a != b;
      fpa_pkg::CMD_MIN: r.value = (a <= b) ? a : b;
      fpa_pkg::CMD_MAX: r.value = (a >= b) ? a : b;
      fpa_pkg::CMD_INC: r = clamp_word(wa + 1);
      fpa_pkg::CMD_DEC: r = clamp_word(wa - 1);
      fpa_pkg::CMD_FROM_INT: r = clamp_word(wa <<< fpa_pkg::FRACTION_BITS);
      default: r.value = a >>> fpa_pkg::FRACTION_BITS;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch in %s: got %h, expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  // predict on accepted operand words, compare accepted result words
  always @(posedge clk_i or negedge rst_ni) begin
    alu_result_t want;
    if (!rst_ni) begin
      fail_count = 0;
      result_count <= 0;
      awaited_results.delete();
      pending_count = 0;
    end else begin
      if (op_mon.valid && op_mon.ready)
        awaited_results.push_back(compute_alu(fpa_pkg::cmd_e'(op_mon.cmd),
                                              op_mon.first_operand,
                                              op_mon.second_operand));
      if (res_mon.valid && res_mon.ready) begin
        result_count <= result_count + 1;
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected word", res_mon.result_value, 32'd0);
        end else begin
          want = awaited_results.pop_front();
          if (res_mon.result_value !== want.value)
            report_mismatch("result_value", res_mon.result_value, want.value);
          if (res_mon.compare_true !== want.cmp)
            report_mismatch("compare_true", 32'(res_mon.compare_true), 32'(want.cmp));
          if (res_mon.status !== want.sts)
            report_mismatch("status", 32'(res_mon.status), 32'(want.sts));
        end
      end
      pending_count = awaited_results.size();
    end
  end
endmodule

// ===== test/tb_fixed_point_alu_q24_8_top.sv =====
// testbench top: drives operand words through the q24.8 alu and gives the verdict
module tb_fixed_point_alu_q24_8_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY     = 42;
  localparam int CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending_count, result_count;
  int   cycle_count = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   hold_off_cycles = 0;
  logic hold_off_req = 1'b0;
  logic hold_off_done = 1'b0;
  int   word_count = 0;

  fpa_in_if  op_ch ();
  fpa_out_if res_ch ();

  fixed_point_alu_q24_8_top dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (op_ch.sink),
    .out_o (res_ch.source)
  );

  fpa_alu_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_mon       (op_ch.sink),
    .res_mon      (res_ch.sink),
    .fail_count   (fail_count),
    .pending_count(pending_count),
    .result_count (result_count)
  );

  always #5 clk_i = ~clk_i;

  // cycle limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial res_ch.ready = 1'b0;
  always @(negedge clk_i) begin
    if (hold_off_req && !hold_off_done) begin
      hold_off_done <= 1'b1;
      hold_off_cycles <= 200;
      res_ch.ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // random operand biased toward edge values
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'($signed($urandom_range(2048)) - 1024);
      3: return 32'($signed($urandom_range(131072)) - 65536);
      4: return {{8{$urandom_range(1) == 1}}, 24'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // offer one operand word and wait until it is accepted
  task automatic send_word(fpa_pkg::cmd_e op, logic [31:0] a, logic [31:0] b);
    while (($urandom_range(99) < send_idle_pct)) begin
      op_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    op_ch.valid <= 1'b1;
    op_ch.cmd <= op;
    op_ch.first_operand <= a;
    op_ch.second_operand <= b;
    @(posedge clk_i);
    while (!op_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    word_count++;
  endtask

  task automatic wait_drained();
    op_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
  endtask

  initial begin
    fpa_pkg::cmd_e ops[16];
    logic [31:0] edges[6];
    op_ch.valid = 1'b0;
    op_ch.cmd = fpa_pkg::CMD_ADD;
    op_ch.first_operand = '0;
    op_ch.second_operand = '0;
    edges = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff, 32'h100, 32'hffffff00};
    for (int i = 0; i < 16; i++) ops[i] = fpa_pkg::cmd_e'(i);
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: every operation on extremes, ties, divide by zero, saturation
    for (int i = 0; i < 16; i++) send_word(ops[i], edges[i % 6], edges[(i + 1) % 6]);
    send_word(fpa_pkg::CMD_MUL, 32'h7fffffff, 32'h7fffffff);
    send_word(fpa_pkg::CMD_MUL, 32'h80, 32'h1);
    send_word(fpa_pkg::CMD_MUL, 32'hffffff80, 32'h1);
    send_word(fpa_pkg::CMD_DIV, 32'h100, 32'h0);
    send_word(fpa_pkg::CMD_DIV, 32'h1, 32'h200);
    send_word(fpa_pkg::CMD_DIV, 32'h80000000, 32'hffffff00);
    send_word(fpa_pkg::CMD_FROM_INT, 32'hff800000, 32'h0);
    send_word(fpa_pkg::CMD_FROM_INT, 32'h007fffff, 32'h0);
    send_word(fpa_pkg::CMD_INC, 32'h7fffffff, 32'h0);
    send_word(fpa_pkg::CMD_DEC, 32'h80000000, 32'h0);
    wait_drained();

    // random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 67 : (ph == 3) ? 8 : 0;
      recv_stall_pct = (ph == 2) ? 67 : (ph == 3) ? 8 : 0;
      if (ph == 0) hold_off_req = 1'b1;
      for (int n = 0; n < 480; n++)
        send_word(fpa_pkg::cmd_e'($urandom_range(15)), pick_operand(), pick_operand());
    end
    wait_drained();
    repeat (LATENCY + 8) @(negedge clk_i);

    $display("sent %0d operand words over all sixteen operations, checked %0d results",
             word_count, result_count);
    $display("phases: free flow, sender gaps, receiver stalls, both, one long hold-off");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
design/fpa_pkg.sv
design/fpa_if.sv
design/fixed_point_alu_q24_8_top.sv
test/fpa_alu_checker.sv
test/tb_fixed_point_alu_q24_8_top.sv
